FILE: rtl/core/ple_pkg.sv
package ple_pkg;

    // Field widths fixed by the interface.
    localparam int CMD_W  = 2;
    localparam int COEF_W = 16;
    localparam int EXP_W  = 8;
    localparam int X_W    = 16;
    localparam int ACC_W  = 48;
    localparam int FRAC_W = 8;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd2;

    // Saturation limits of the accumulator.
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Controls shared by every coefficient cell.
    typedef struct packed {
        logic clr;
        logic shift;
    } cell_ctl_t;

    // Controls of the multiply-accumulate unit.
    typedef struct packed {
        logic clr;
        logic start;
        logic step;
    } mac_ctl_t;

endpackage

FILE: rtl/core/polynomial_load_and_evaluate_top.sv
// Channel | Direction | Handshake          | Payload
// in      | request   | in_valid/in_stall  | cmd, coef, exponent, x_value
// out     | result    | out_valid/out_stall| value, saturated
//
// Clear and load requests give no result.
// An evaluate request runs MAX_DEGREE+1 Horner steps in the single multiply-accumulate
// unit, fed by the coefficient ring rotating one cell per cycle; the result is then
// offered through ST_FIN and the output register, waiting in ST_FIN while that register is full.
// Reset clears all coefficients, the accumulator and all control state at once.
// in_stall is high while an evaluation runs or its result waits for a full output register.
module polynomial_load_and_evaluate_top
#(
    parameter int MAX_DEGREE = 15
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ple_pkg::CMD_W-1:0]           cmd,
    input  logic signed [ple_pkg::COEF_W-1:0]   coef,
    input  logic [ple_pkg::EXP_W-1:0]           exponent,
    input  logic signed [ple_pkg::X_W-1:0]      x_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ple_pkg::ACC_W-1:0]    value,
    output logic                                saturated
);

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int CNT_W = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                        state_reg;
    logic [1:0]                        state_next;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [CNT_W-1:0]                  cnt_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic signed [ple_pkg::ACC_W-1:0]  value_reg;
    logic                              sat_out_reg;

    logic                              in_take;
    logic                              out_free;
    logic                              out_load;
    ple_pkg::cell_ctl_t                cell_ctl;
    ple_pkg::mac_ctl_t                 mac_ctl;
    logic signed [ple_pkg::COEF_W-1:0] ring [DEPTH];
    logic signed [ple_pkg::ACC_W-1:0]  mac_acc;
    logic                              mac_sat;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == ST_FIN) && out_free;

    // Controls for the ring and the accumulator.
    always_comb
    begin
        cell_ctl.clr   = in_take && (cmd == ple_pkg::CMD_CLEAR);
        cell_ctl.shift = (state_reg == ST_RUN);
        mac_ctl.clr    = cell_ctl.clr;
        mac_ctl.start  = in_take && (cmd == ple_pkg::CMD_EVAL);
        mac_ctl.step   = (state_reg == ST_RUN);
    end

    // Ring of coefficient cells; the top cell feeds the multiply-accumulate unit
    // and wraps around to cell zero, so a full pass restores the order.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam int PREV = (i == 0) ? DEPTH - 1 : i - 1;
        logic wr_en;

        assign wr_en = in_take && (cmd == ple_pkg::CMD_LOAD) &&
                       (exponent == ple_pkg::EXP_W'(i));

        ple_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl),
            .wr_en     (wr_en),
            .wr_coef   (coef),
            .prev_coef (ring[PREV]),
            .coef_out  (ring[i])
        );
    end

    ple_mac u_mac
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .x_in    (x_value),
        .coef_in (ring[DEPTH-1]),
        .acc     (mac_acc),
        .sat     (mac_sat)
    );

    // Sequencer: idle, Horner steps, hand-off to the output register.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (mac_ctl.start)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAX_DEGREE))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            value_reg   <= mac_acc;
            sat_out_reg <= mac_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign saturated = sat_out_reg;

endmodule

FILE: rtl/core/ple_cell.sv
module ple_cell
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ple_pkg::cell_ctl_t                  ctl,
    input  logic                                wr_en,
    input  logic signed [ple_pkg::COEF_W-1:0]   wr_coef,
    input  logic signed [ple_pkg::COEF_W-1:0]   prev_coef,
    output logic signed [ple_pkg::COEF_W-1:0]   coef_out
);

    logic signed [ple_pkg::COEF_W-1:0] coef_reg;
    logic signed [ple_pkg::COEF_W-1:0] coef_next;

    // A clear wins over a load; the ring shift only runs during an evaluation.
    always_comb
    begin
        coef_next = coef_reg;
        if (ctl.clr)
        begin
            coef_next = '0;
        end
        else if (wr_en)
        begin
            coef_next = wr_coef;
        end
        else if (ctl.shift)
        begin
            coef_next = prev_coef;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef_out = coef_reg;

endmodule

FILE: rtl/core/ple_mac.sv
module ple_mac
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  ple_pkg::mac_ctl_t                   ctl,
    input  logic signed [ple_pkg::X_W-1:0]      x_in,
    input  logic signed [ple_pkg::COEF_W-1:0]   coef_in,
    output logic signed [ple_pkg::ACC_W-1:0]    acc,
    output logic                                sat
);

    localparam int PROD_W = ple_pkg::ACC_W + ple_pkg::X_W;
    localparam int SHR_W  = PROD_W - ple_pkg::FRAC_W;
    localparam int SUM_W  = SHR_W + 1;
    localparam int SC_W   = ple_pkg::COEF_W + ple_pkg::FRAC_W;

    logic signed [ple_pkg::ACC_W-1:0] acc_reg;
    logic signed [ple_pkg::ACC_W-1:0] acc_next;
    logic                             sat_reg;
    logic                             sat_next;
    logic signed [ple_pkg::X_W-1:0]   x_reg;
    logic signed [ple_pkg::X_W-1:0]   x_next;

    logic signed [PROD_W-1:0]         prod;
    logic signed [SHR_W-1:0]          shr;
    logic signed [SC_W-1:0]           coef_sc;
    logic signed [SUM_W-1:0]          sum;
    logic                             in_range;
    logic signed [ple_pkg::ACC_W-1:0] step_acc;

    // One Horner step: floor(acc * x / 256) + coef * 256, clipped to 48 bits.
    assign prod     = PROD_W'(acc_reg) * PROD_W'(x_reg);
    assign shr      = prod[PROD_W-1:ple_pkg::FRAC_W];
    assign coef_sc  = {coef_in, {ple_pkg::FRAC_W{1'b0}}};
    assign sum      = SUM_W'(shr) + SUM_W'(coef_sc);
    assign in_range = (sum[SUM_W-1:ple_pkg::ACC_W-1] == '0) ||
                      (sum[SUM_W-1:ple_pkg::ACC_W-1] == '1);

    always_comb
    begin
        if (in_range)
        begin
            step_acc = sum[ple_pkg::ACC_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            step_acc = ple_pkg::ACC_MIN;
        end
        else
        begin
            step_acc = ple_pkg::ACC_MAX;
        end
    end

    // Accumulator, sticky clip flag and the held evaluation point.
    always_comb
    begin
        acc_next = acc_reg;
        sat_next = sat_reg;
        x_next   = x_reg;
        if (ctl.clr)
        begin
            acc_next = '0;
            sat_next = 1'b0;
        end
        else if (ctl.start)
        begin
            acc_next = '0;
            sat_next = 1'b0;
            x_next   = x_in;
        end
        else if (ctl.step)
        begin
            acc_next = step_acc;
            sat_next = sat_reg | ~in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            sat_reg <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
    end

    assign acc = acc_reg;
    assign sat = sat_reg;

endmodule
